/* rtl/aes_pkg.sv */
// ============================================================================
// aes_pkg
// shared types, constants and round functions for the aes-128 pipeline
// ============================================================================
package aes_pkg;

    localparam int NumRounds = 10;

    // cycles for a fresh key to run through the registered schedule
    localparam logic [3:0] KeySettle = 4'(NumRounds + 1);

    // configuration register indexes
    localparam logic [1:0] RegKeyHigh  = 2'd0;
    localparam logic [1:0] RegKeyLow   = 2'd1;
    localparam logic [1:0] RegDir      = 2'd2;

    typedef logic [127:0] block_t;

    // forward s-box
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    // inverse s-box
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    // multiply by two in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // round constant of round r, 1 to 10
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // forward round: subbytes, shiftrows, optional mixcolumns
    function automatic block_t enc_round(input block_t s, input logic mix);
        logic [7:0] a [16];
        logic [7:0] b [16];
        block_t o;
        for (int i = 0; i < 16; i++) a[i] = sbox(get_byte(s, i));
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) b[4*c+r] = a[4*((c+r)%4)+r];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                logic [7:0] x0, x1, x2, x3;
                x0 = b[4*c+r];
                x1 = b[4*c+(r+1)%4];
                x2 = b[4*c+(r+2)%4];
                x3 = b[4*c+(r+3)%4];
                o[127-8*(4*c+r) -: 8] = mix ? (xtime(x0) ^ xtime(x1) ^ x1 ^ x2 ^ x3) : x0;
            end
        return o;
    endfunction

    // inverse round body: invshiftrows, invsubbytes, key, optional invmixcolumns
    function automatic block_t dec_round(input block_t s, input block_t k,
                                         input logic mix);
        logic [7:0] a [16];
        logic [7:0] b [16];
        block_t o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) a[4*((c+r)%4)+r] = get_byte(s, 4*c+r);
        for (int i = 0; i < 16; i++) b[i] = inv_sbox(a[i]) ^ get_byte(k, i);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                logic [7:0] x0, x1, x2, x3, y;
                x0 = b[4*c+r];
                x1 = b[4*c+(r+1)%4];
                x2 = b[4*c+(r+2)%4];
                x3 = b[4*c+(r+3)%4];
                // 0e x0 ^ 0b x1 ^ 0d x2 ^ 09 x3
                y = xtime(xtime(xtime(x0 ^ x1 ^ x2 ^ x3))) ^ xtime(xtime(x0 ^ x2))
                    ^ xtime(x0 ^ x1) ^ x1 ^ x2 ^ x3;
                o[127-8*(4*c+r) -: 8] = mix ? y : b[4*c+r];
            end
        return o;
    endfunction

endpackage

/* rtl/aes_keys.sv */
// ============================================================================
// aes_keys
// configuration registers and round key expansion, one key a stage
// ============================================================================
module aes_keys
    import aes_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         dir,
    output logic         keys_ready,
    output block_t       rkeys [NumRounds+1]
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        dir_reg;
    logic [1:0]  idx;
    logic [3:0]  settle_reg;

    assign idx = paddr[4:3];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= 64'h3132333435363738;
            key_low_reg  <= 64'h3930313233343536;
            dir_reg      <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (idx)
                RegKeyHigh: key_high_reg <= pwdata;
                RegKeyLow:  key_low_reg  <= pwdata;
                RegDir:     dir_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (idx)
            RegKeyHigh: prdata = key_high_reg;
            RegKeyLow:  prdata = key_low_reg;
            RegDir:     prdata = {63'd0, dir_reg};
            default:    prdata = 64'd0;
        endcase
    end

    // hold input off after reset and any apb write until the key has run through the whole schedule
    always_ff @(posedge aclk) begin
        if (!aresetn) settle_reg <= KeySettle;
        else if (psel && penable && pwrite) settle_reg <= KeySettle;
        else if (settle_reg != 4'd0) settle_reg <= settle_reg - 4'd1;
    end

    assign keys_ready = (settle_reg == 4'd0);

    // key schedule, registered one round at a time
    block_t rk_reg [NumRounds+1];
    always_ff @(posedge aclk) begin
        rk_reg[0] <= {key_high_reg, key_low_reg};
        for (int r = 1; r <= NumRounds; r++)
            rk_reg[r] <= next_key(rk_reg[r-1], rcon(4'(r)));
    end

    assign rkeys = rk_reg;
    assign dir   = dir_reg;

endmodule

/* rtl/aes_round.sv */
// ============================================================================
// aes_round
// one pipeline stage: a single encrypt or decrypt round with valid and stall
// ============================================================================
module aes_round
    import aes_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   advance,
    input  logic   in_valid,
    input  block_t in_data,
    input  logic   dir,
    input  logic   last,
    input  block_t enc_key,
    input  block_t dec_key,
    output logic   out_valid,
    output block_t out_data
);

    logic   valid_reg;
    block_t data_reg;
    block_t data_next;

    // round function for the chosen direction
    always_comb begin
        if (dir) data_next = dec_round(in_data, dec_key, !last);
        else     data_next = enc_round(in_data, !last) ^ enc_key;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (advance) valid_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (advance) data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/aes128_block_cipher.sv */
// ============================================================================
// aes128_block_cipher
// aes-128 ecb encrypt or decrypt, eleven-stage pipeline, unless stalled one block a cycle
// ============================================================================
// channel | direction | fields
// s_      | in        | tdata = block_high (low half), block_low (high half)
// m_      | out       | tdata = result_high (low half), result_low (high half)
// apb     | in        | key_high at 0x00, key_low at 0x08, direction at 0x10
//
// one block enters per cycle while s_tready is high; a block passes whitening,
// then ten rounds, each round stage registered. round keys run through the
// registered schedule; s_tready stays low after reset and any register write
// until they settle. all stages halt while a result waits with m_tready low;
// else s_tready is high if keys have settled and the output is empty or taken.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // block_high [63:0], block_low [127:64]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // result_high [63:0], result_low [127:64]
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    logic   dir;
    logic   keys_ready;
    block_t rkeys [NumRounds+1];
    logic   advance;
    logic   v [NumRounds+1];
    block_t d [NumRounds+1];
    block_t blk_in;
    logic   v0_reg;
    block_t d0_reg;

    assign pready = 1'b1;

    aes_keys u_keys (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .dir(dir), .keys_ready(keys_ready), .rkeys(rkeys)
    );

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance && keys_ready;
    assign blk_in   = {s_tdata[63:0], s_tdata[127:64]};

    // initial whitening stage
    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (advance) v0_reg <= s_tvalid && keys_ready;
    end
    always_ff @(posedge aclk) begin
        if (advance) d0_reg <= blk_in ^ (dir ? rkeys[NumRounds] : rkeys[0]);
    end
    assign v[0] = v0_reg;
    assign d[0] = d0_reg;

    // ten round stages
    for (genvar r = 1; r <= NumRounds; r++) begin : g_round
        aes_round u_round (
            .aclk(aclk), .aresetn(aresetn), .advance(advance),
            .in_valid(v[r-1]), .in_data(d[r-1]), .dir(dir),
            .last(r == NumRounds), .enc_key(rkeys[r]),
            .dec_key(rkeys[NumRounds-r]),
            .out_valid(v[r]), .out_data(d[r])
        );
    end

    assign m_tvalid = v[NumRounds];
    assign m_tdata  = {d[NumRounds][63:0], d[NumRounds][127:64]};

`ifndef SYNTH
    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // input is refused only when the output is blocked or keys are settling
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready) || !keys_ready)
        else $error("input refused without stall");
    // an accepted block reaches the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v0_reg)
        else $error("accepted block lost");
`endif

endmodule

/* tb/testbench.sv */
// ============================================================================
// aes-128 block cipher testbench
// streams blocks through the pipeline under both directions and several keys,
// predicts every result with a local aes-128 model and checks it in order
// ============================================================================
module testbench;
    import aes_pkg::*;

    localparam int RandomBlocks = 1950;
    localparam int Latency      = 11;
    localparam int WatchLimit   = 20000;

    // local copies of the s-box tables for the predictor
    typedef logic [7:0] byte_tab_t [256];

    function automatic byte_tab_t fwd_table();
        byte_tab_t t;
        logic [7:0] p, q, x;
        for (int i = 0; i < 256; i++) t[i] = 8'h00;
        p = 8'h01;
        q = 8'h01;
        // walk the generator 3 and its inverse, applying the affine map
        do begin
            p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
            q = q ^ (q << 1);
            q = q ^ (q << 2);
            q = q ^ (q << 4);
            if (q[7]) q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]};
            t[p] = x ^ 8'h63;
        end while (p != 8'h01);
        t[0] = 8'h63;
        return t;
    endfunction

    byte_tab_t sub_fwd, sub_inv;

    function automatic logic [7:0] dbl8(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc ^= x;
            x = dbl8(x);
        end
        return acc;
    endfunction

    typedef logic [7:0] state_t [16];

    // aes-128 of one block under the given key and direction
    function automatic logic [127:0] aes_cipher(input logic [127:0] blk,
                                                input logic [127:0] key,
                                                input logic decrypt);
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0] rc;
        state_t s, u;
        logic [7:0] m [4];
        logic [127:0] o;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_fwd[t[31:24]], sub_fwd[t[23:16]], sub_fwd[t[15:8]],
                     sub_fwd[t[7:0]]} ^ {rc, 24'h0};
                rc = dbl8(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        if (decrypt) begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int i = 0; i < 16; i++)
            s[i] ^= w[(decrypt ? 40 : 0) + i/4][31-8*(i%4) -: 8];
        for (int k = 1; k <= 10; k++) begin
            int rnd;
            rnd = decrypt ? 10 - k : k;
            // (inverse) shift rows and substitution
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                    if (decrypt) u[4*((c+r)%4)+r] = sub_inv[s[4*c+r]];
                    else u[4*c+r] = sub_fwd[s[4*((c+r)%4)+r]];
                end
            if (decrypt)
                for (int i = 0; i < 16; i++) u[i] ^= w[4*rnd + i/4][31-8*(i%4) -: 8];
            // column mixing except on the last round
            if (k != 10) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        s[4*c+r] = gmul(u[4*c+r], m[0]) ^ gmul(u[4*c+(r+1)%4], m[1])
                                 ^ gmul(u[4*c+(r+2)%4], m[2]) ^ gmul(u[4*c+(r+3)%4], m[3]);
            end else begin
                s = u;
            end
            if (!decrypt)
                for (int i = 0; i < 16; i++) s[i] ^= w[4*rnd + i/4][31-8*(i%4) -: 8];
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
        return o;
    endfunction

    // scoreboard of predicted cipher outputs
    class cipher_board;
        logic [127:0] pending [$];
        int errors;
        int checked;

        function void note_block(logic [127:0] res);
            pending.push_back(res);
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] want;
            if (pending.size() == 0) begin
                $error("unexpected result %h %h", hi, lo);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (hi !== want[127:64]) begin
                $error("result_high expected %h actual %h", want[127:64], hi);
                errors++;
            end
            if (lo !== want[63:0]) begin
                $error("result_low expected %h actual %h", want[63:0], lo);
                errors++;
            end
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [63:0]   pwdata = '0;
    logic [63:0]   prdata;
    logic          pready;

    cipher_board board;
    logic [63:0] cur_key_hi = 64'h3132333435363738;
    logic [63:0] cur_key_lo = 64'h3930313233343536;
    logic        cur_decrypt = 1'b0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;
    int          idle_cycles = 0;
    int          dec_blocks = 0;
    int          enc_blocks = 0;

    aes128_block_cipher dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && (calm || $urandom_range(99) >= 8);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata[63:0], m_tdata[127:64]);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one register write over apb
    task automatic reg_write(input logic [4:0] addr, input logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            {RegKeyHigh, 3'b000}: cur_key_hi = val;
            {RegKeyLow, 3'b000}:  cur_key_lo = val;
            {RegDir, 3'b000}:     cur_decrypt = val[0];
            default: ;
        endcase
    endtask

    // one block transaction, with a random gap before it unless calm is set
    task automatic send_block(input logic [127:0] blk);
        if (!calm)
            while ($urandom_range(99) < 8) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        s_tvalid <= 1'b1;
        s_tdata <= {blk[63:0], blk[127:64]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_block(aes_cipher(blk, {cur_key_hi, cur_key_lo}, cur_decrypt));
        if (cur_decrypt) dec_blocks++; else enc_blocks++;
    endtask

    // let the pipe drain and the round keys settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (Latency + 2) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [127:0] rand_block();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 128'h1 << $urandom_range(127);
            default: return {rand64(), rand64()};
        endcase
    endfunction

    initial begin
        board = new();
        sub_fwd = fwd_table();
        for (int i = 0; i < 256; i++) sub_inv[sub_fwd[i]] = i[7:0];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset key, field extremes, both directions
        send_block('0);
        send_block('1);
        send_block(128'h3243f6a8885a308d313198a2e0370734);
        send_block({64'h8000000000000000, 64'h1});
        drain();
        reg_write({RegKeyHigh, 3'b000}, 64'h2b7e151628aed2a6);
        reg_write({RegKeyLow, 3'b000}, 64'habf7158809cf4f3c);
        drain();
        send_block(128'h3243f6a8885a308d313198a2e0370734);
        send_block(128'h00112233445566778899aabbccddeeff);
        drain();
        reg_write({RegDir, 3'b000}, 64'hffff_ffff_ffff_ffff);
        drain();
        send_block(128'h3925841d02dc09fbdc118597196a0b32);
        send_block('0);
        send_block('1);
        drain();
        reg_write({RegKeyHigh, 3'b000}, '0);
        reg_write({RegKeyLow, 3'b000}, '0);
        drain();
        send_block('0);
        send_block('1);
        drain();
        reg_write({RegKeyHigh, 3'b000}, '1);
        reg_write({RegKeyLow, 3'b000}, '1);
        reg_write({RegDir, 3'b000}, 64'h2);
        drain();
        send_block('0);
        send_block('1);
        drain();

        // random phases with fresh keys and direction
        for (int ph = 0; ph < 6; ph++) begin
            reg_write({RegKeyHigh, 3'b000}, rand64());
            reg_write({RegKeyLow, 3'b000}, rand64());
            reg_write({RegDir, 3'b000}, {$urandom(), $urandom()});
            drain();
            calm = (ph == 2);
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < RandomBlocks / 6; n++) send_block(rand_block());
            calm = 1'b0;
            drain();
        end

        $display("covered %0d encryptions and %0d decryptions, %0d results checked",
                 enc_blocks, dec_blocks, board.checked);
        $display("keys: reset, all-zero, all-one, a standard vector and six random ones");
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
